// ----- rtl/core/radius_of_gyration_per_chain_unit_defines.svh -----
// Assertion macros for the radius of gyration unit.
`ifndef RADIUS_OF_GYRATION_PER_CHAIN_UNIT_DEFINES_SVH
`define RADIUS_OF_GYRATION_PER_CHAIN_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RGPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgpc assertion failed");
`define RGPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgpc assertion failed");
`else
`define RGPC_ASSERT_IMP(lbl, ante, cons)
`define RGPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/rgpc_pkg.sv -----
// Shared types and constants of the radius of gyration unit.
`default_nettype none
package rgpc_pkg;
  localparam int CHAIN_W = 6;
  localparam int POS_W   = 24;
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 36;
  localparam int SQ_W    = 60;
  localparam int FRAME_W = 32;
  localparam int GYR_W   = 48;
  localparam int ACC_W   = 74;
  localparam int NUM_W   = 72;
  localparam int DEN_W   = 26;
  localparam int DIG_W   = 12;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_LAST  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic [2:0][SUM_W-1:0]   s;
    logic [2:0][SQ_W-1:0]    q;
  } entry_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      frame;
    logic [CHAIN_W-1:0]      chain;
    logic                    last;
    entry_t                  e;
  } job_t;
endpackage
`default_nettype wire

// ----- rtl/core/radius_of_gyration_per_chain_unit.sv -----
// Top level of the per-chain mean square radius of gyration unit.
// An atom beat reads the chain's accumulator entry from the per-chain
// memory, then updates it and writes it back. On the frame's last atom the
// front sweeps the chains in range into a two-entry job queue, clears the
// sums through per-chain valid bits (no clearing pass) and takes the next
// frame's atoms. The input stays stalled until the sweep has pushed its last
// chain, so once the queue is full the sweep runs at the back end's pace.
// For each result the back end takes the job, runs 15 steps of a shared
// 60x12 multiplier, one subtract and a 72-step bit-serial divider, then
// holds the result in the output register until it is taken. An empty or
// overflowed chain goes from taking the job straight to the output register.
`default_nettype none
`include "radius_of_gyration_per_chain_unit_defines.svh"
module radius_of_gyration_per_chain_unit #(
  parameter int CHAIN_SLOTS = 64,
  parameter int MAX_ATOMS_PER_CHAIN = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rgpc_pkg::CHAIN_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rgpc_pkg::CHAIN_W-1:0] in_chain_id,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_z,
  input  logic                         in_frame_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgpc_pkg::FRAME_W-1:0] out_frame_number,
  output logic [rgpc_pkg::CHAIN_W-1:0] out_result_chain,
  output logic [rgpc_pkg::GYR_W-1:0]   out_gyration_sq,
  output logic [1:0]                   out_status,
  output logic                         out_last_of_frame
);
  import rgpc_pkg::*;

  logic [CHAIN_W-1:0] first_chain_r;
  logic [CHAIN_W-1:0] last_chain_r;
  logic               q_push;
  job_t               q_push_job;
  logic               q_full;
  logic               q_pop;
  job_t               q_pop_job;
  logic               q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_chain_r <= '0;
      last_chain_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST: first_chain_r <= cfg_wdata;
        CFG_LAST:  last_chain_r  <= cfg_wdata;
        default:   first_chain_r <= first_chain_r;
      endcase
    end
  end

  rgpc_front #(
    .CHAIN_SLOTS(CHAIN_SLOTS),
    .MAX_ATOMS_PER_CHAIN(MAX_ATOMS_PER_CHAIN)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .first_chain(first_chain_r),
    .last_chain(last_chain_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_chain_id(in_chain_id),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .in_frame_end(in_frame_end),
    .push(q_push),
    .push_job(q_push_job),
    .q_full(q_full)
  );

  rgpc_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_job(q_push_job),
    .full(q_full),
    .pop(q_pop),
    .pop_job(q_pop_job),
    .nonempty(q_nonempty)
  );

  rgpc_back #(
    .MAX_ATOMS_PER_CHAIN(MAX_ATOMS_PER_CHAIN)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_nonempty(q_nonempty),
    .q_job(q_pop_job),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_number(out_frame_number),
    .out_result_chain(out_result_chain),
    .out_gyration_sq(out_gyration_sq),
    .out_status(out_status),
    .out_last_of_frame(out_last_of_frame)
  );

  `RGPC_ASSERT_IMP(a_empty_zero, out_valid && out_status == STAT_EMPTY, out_gyration_sq == '0)
  `RGPC_ASSERT_NEXT(a_atom_two_cycle, in_valid && !in_stall, in_stall)
  `RGPC_ASSERT_IMP(a_push_not_full, q_push, !q_full)
endmodule
`default_nettype wire

// ----- rtl/core/rgpc_front.sv -----
// Front end: per-chain accumulation memory and frame-end sweep into the job queue.
`default_nettype none
module rgpc_front #(
  parameter int CHAIN_SLOTS = 64,
  parameter int MAX_ATOMS_PER_CHAIN = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rgpc_pkg::CHAIN_W-1:0] first_chain,
  input  logic [rgpc_pkg::CHAIN_W-1:0] last_chain,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rgpc_pkg::CHAIN_W-1:0] in_chain_id,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [rgpc_pkg::POS_W-1:0] in_pos_z,
  input  logic                         in_frame_end,
  output logic                         push,
  output rgpc_pkg::job_t               push_job,
  input  logic                         q_full
);
  import rgpc_pkg::*;

  localparam int AW = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
  localparam logic [CHAIN_W:0]   SLOTS = (CHAIN_W+1)'(CHAIN_SLOTS);
  localparam logic [CHAIN_W-1:0] TOP   = CHAIN_W'(CHAIN_SLOTS - 1);
  localparam logic [CNT_W-1:0]   MAXN  = CNT_W'(MAX_ATOMS_PER_CHAIN);

  typedef enum logic [1:0] {F_IDLE, F_ACC, F_SW_RD, F_SW_PUSH} fstate_t;

  fstate_t                 state_r;
  entry_t                  mem [CHAIN_SLOTS];
  entry_t                  rd_r;
  logic                    rd_valid_r;
  logic [CHAIN_SLOTS-1:0]  valid_r;
  logic [CHAIN_W-1:0]      chain_r;
  logic                    hit_r;
  logic                    end_r;
  logic [2:0][POS_W-1:0]   pos_r;
  logic [CHAIN_W-1:0]      k_r;
  logic [FRAME_W-1:0]      frame_r;

  logic                    accept;
  logic                    in_hit;
  logic                    range_ok;
  logic [CHAIN_W-1:0]      hi;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  entry_t                  cur;
  entry_t                  acc_nxt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);
  assign hi       = (last_chain > TOP) ? TOP : last_chain;
  assign range_ok = (first_chain <= last_chain) && ({1'b0, first_chain} < SLOTS);
  assign in_hit   = ({1'b0, in_chain_id} < SLOTS) && (in_chain_id >= first_chain) &&
                    (in_chain_id <= last_chain);
  assign rd_en    = accept || (state_r == F_SW_RD);
  assign rd_addr  = (state_r == F_SW_RD) ? k_r[AW-1:0] : in_chain_id[AW-1:0];
  assign wr_en    = (state_r == F_ACC) && hit_r;
  assign cur      = rd_valid_r ? rd_r : '0;

  always_comb begin
    logic signed [2*POS_W-1:0] sq;
    acc_nxt = cur;
    sq      = '0;
    if (cur.n < MAXN) begin
      acc_nxt.n = cur.n + CNT_W'(1);
      for (int a = 0; a < 3; a++) begin
        sq = $signed(pos_r[a]) * $signed(pos_r[a]);
        acc_nxt.s[a] = cur.s[a] + SUM_W'($signed(pos_r[a]));
        acc_nxt.q[a] = cur.q[a] + SQ_W'($unsigned(sq));
      end
    end else begin
      acc_nxt.n = MAXN + CNT_W'(1);
    end
  end

  // sweep pushes the chain just read; empty slots read as zero
  assign push           = (state_r == F_SW_PUSH) && !q_full;
  assign push_job.frame = frame_r;
  assign push_job.chain = k_r;
  assign push_job.last  = (k_r == hi);
  assign push_job.e     = cur;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (wr_en) begin
      mem[chain_r[AW-1:0]] <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      valid_r <= '0;
      frame_r <= '0;
      k_r     <= '0;
      chain_r <= '0;
      hit_r   <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            chain_r  <= in_chain_id;
            hit_r    <= in_hit;
            end_r    <= in_frame_end;
            pos_r[0] <= in_pos_x;
            pos_r[1] <= in_pos_y;
            pos_r[2] <= in_pos_z;
            state_r  <= F_ACC;
          end
        end
        F_ACC: begin
          if (wr_en) begin
            valid_r[chain_r[AW-1:0]] <= 1'b1;
          end
          if (!end_r) begin
            state_r <= F_IDLE;
          end else if (range_ok) begin
            k_r     <= first_chain;
            state_r <= F_SW_RD;
          end else begin
            valid_r <= '0;
            frame_r <= frame_r + FRAME_W'(1);
            state_r <= F_IDLE;
          end
        end
        F_SW_RD: begin
          state_r <= F_SW_PUSH;
        end
        F_SW_PUSH: begin
          if (!q_full) begin
            if (k_r == hi) begin
              valid_r <= '0;
              frame_r <= frame_r + FRAME_W'(1);
              state_r <= F_IDLE;
            end else begin
              k_r     <= k_r + CHAIN_W'(1);
              state_r <= F_SW_RD;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/rgpc_queue.sv -----
// Two-entry job queue between front and back.
`default_nettype none
module rgpc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rgpc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rgpc_pkg::job_t pop_job,
  output logic           nonempty
);
  import rgpc_pkg::*;

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign pop_job  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/rgpc_back.sv -----
// Back end: shared digit multiplier, bit-serial divider and result register.
`default_nettype none
module rgpc_back #(
  parameter int MAX_ATOMS_PER_CHAIN = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_nonempty,
  input  rgpc_pkg::job_t               q_job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgpc_pkg::FRAME_W-1:0] out_frame_number,
  output logic [rgpc_pkg::CHAIN_W-1:0] out_result_chain,
  output logic [rgpc_pkg::GYR_W-1:0]   out_gyration_sq,
  output logic [1:0]                   out_status,
  output logic                         out_last_of_frame
);
  import rgpc_pkg::*;

  localparam logic [CNT_W-1:0] MAXN  = CNT_W'(MAX_ATOMS_PER_CHAIN);
  localparam int               STEPS = 5;
  localparam int               DIVW  = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUB, B_DIV, B_OUT} bstate_t;

  bstate_t             state_r;
  job_t                job_r;
  logic [1:0]          axis_r;
  logic [2:0]          sub_r;
  logic [ACC_W-1:0]    pos_r;
  logic [ACC_W-1:0]    neg_r;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DIVW-1:0]     div_cnt_r;
  logic                out_valid_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [CHAIN_W-1:0]  chain_r;
  logic [GYR_W-1:0]    gyr_r;
  logic [1:0]          stat_r;
  logic                last_r;

  logic [SUM_W-1:0]    s_ax;
  logic [SUM_W-1:0]    m_ax;
  logic [SQ_W-1:0]     opa;
  logic [DIG_W-1:0]    dig;
  logic [NUM_W-1:0]    prod;
  logic [ACC_W-1:0]    term;
  logic [2*CNT_W-1:0]  nn;
  logic [DEN_W:0]      trial;
  logic                qbit;

  assign pop = (state_r == B_IDLE) && q_nonempty;
  assign nn  = q_job.e.n * q_job.e.n;

  // digits 0-1 form n*Q, digits 2-4 form |S|*|S|
  always_comb begin
    s_ax = job_r.e.s[axis_r];
    m_ax = s_ax[SUM_W-1] ? (SUM_W'(0) - s_ax) : s_ax;
    opa  = '0;
    dig  = '0;
    term = '0;
    unique case (sub_r)
      3'd0: begin
        opa = job_r.e.q[axis_r];
        dig = job_r.e.n[DIG_W-1:0];
      end
      3'd1: begin
        opa = job_r.e.q[axis_r];
        dig = DIG_W'(job_r.e.n[CNT_W-1:DIG_W]);
      end
      3'd2: begin
        opa = SQ_W'(m_ax);
        dig = m_ax[DIG_W-1:0];
      end
      3'd3: begin
        opa = SQ_W'(m_ax);
        dig = m_ax[2*DIG_W-1:DIG_W];
      end
      3'd4: begin
        opa = SQ_W'(m_ax);
        dig = m_ax[3*DIG_W-1:2*DIG_W];
      end
      default: begin
        opa = '0;
        dig = '0;
      end
    endcase
    prod = opa * dig;
    unique case (sub_r)
      3'd1, 3'd3: term = ACC_W'({prod, {DIG_W{1'b0}}});
      3'd4:       term = ACC_W'({prod, {(2*DIG_W){1'b0}}});
      default:    term = ACC_W'(prod);
    endcase
  end

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  assign out_valid         = out_valid_r;
  assign out_frame_number  = frame_r;
  assign out_result_chain  = chain_r;
  assign out_gyration_sq   = gyr_r;
  assign out_status        = stat_r;
  assign out_last_of_frame = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      sub_r       <= '0;
      div_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (q_nonempty) begin
            job_r   <= q_job;
            frame_r <= q_job.frame;
            chain_r <= q_job.chain;
            last_r  <= q_job.last;
            den_r   <= DEN_W'(nn);
            pos_r   <= '0;
            neg_r   <= '0;
            axis_r  <= '0;
            sub_r   <= '0;
            if (q_job.e.n == '0) begin
              gyr_r       <= '0;
              stat_r      <= STAT_EMPTY;
              out_valid_r <= 1'b1;
              state_r     <= B_OUT;
            end else if (q_job.e.n > MAXN) begin
              gyr_r       <= '0;
              stat_r      <= STAT_OVF;
              out_valid_r <= 1'b1;
              state_r     <= B_OUT;
            end else begin
              state_r <= B_MUL;
            end
          end
        end
        B_MUL: begin
          if (sub_r < 3'd2) pos_r <= pos_r + term;
          else              neg_r <= neg_r + term;
          if (sub_r == 3'(STEPS - 1)) begin
            sub_r <= '0;
            if (axis_r == 2'd2) state_r <= B_SUB;
            else                axis_r  <= axis_r + 2'd1;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        B_SUB: begin
          num_r     <= (pos_r >= neg_r) ? NUM_W'(pos_r - neg_r) : '0;
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= B_DIV;
        end
        B_DIV: begin
          // restoring division, quotient bits shift into num_r
          rem_r     <= qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
          num_r     <= {num_r[NUM_W-2:0], qbit};
          div_cnt_r <= div_cnt_r + DIVW'(1);
          if (div_cnt_r == DIVW'(NUM_W - 1)) begin
            state_r     <= B_OUT;
            out_valid_r <= 1'b1;
            if ({num_r[NUM_W-2:GYR_W-1]} != '0) begin
              gyr_r  <= '1;
              stat_r <= STAT_OVF;
            end else begin
              gyr_r  <= {num_r[GYR_W-2:0], qbit};
              stat_r <= STAT_OK;
            end
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the per-chain radius of gyration unit.
`timescale 1ns / 1ps
module testbench;
  import rgpc_pkg::*;

  localparam int SLOTS     = 64;
  localparam int MAX_ATOMS = 4096;
  localparam int SETTLE    = 200;
  localparam int STALL_MAX = 3000;  // cycles without any beat

  typedef enum bit {ROW_ATOM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic                     reg_idx;
    bit [CHAIN_W-1:0]         chain;
    bit signed [POS_W-1:0]    x, y, z;
    bit                       fend;
    bit                       chk;
    bit [GYR_W-1:0]           gyr;
    logic [1:0]               st;
  } row_t;

  typedef struct {
    bit [FRAME_W-1:0] frame;
    bit [CHAIN_W-1:0] chain;
    bit [GYR_W-1:0]   gyr;
    logic [1:0]       st;
    bit               last;
  } gyr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FIRST;
  logic [CHAIN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAIN_W-1:0] in_chain_id = '0;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FRAME_W-1:0] out_frame_number;
  logic [CHAIN_W-1:0] out_result_chain;
  logic [GYR_W-1:0] out_gyration_sq;
  logic [1:0] out_status;
  logic out_last_of_frame;

  radius_of_gyration_per_chain_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the block's accumulators and registers
  bit [CHAIN_W-1:0] sh_first, sh_last;
  int unsigned      sh_count [SLOTS];
  longint           sh_sum [SLOTS][3];
  bit [63:0]        sh_sq [SLOTS][3];
  bit [FRAME_W-1:0] sh_frame;

  gyr_result_t pending_results[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0, atoms_sent = 0, results_seen = 0, frames_sent = 0;
  int quiet_cycles = 0;

  function automatic void clear_sums();
    foreach (sh_count[c]) begin
      sh_count[c] = 0;
      for (int a = 0; a < 3; a++) begin
        sh_sum[c][a] = 0;
        sh_sq[c][a] = 0;
      end
    end
  endfunction

  function automatic void predict_atom(bit [CHAIN_W-1:0] c, bit signed [POS_W-1:0] x,
                                       bit signed [POS_W-1:0] y, bit signed [POS_W-1:0] z,
                                       bit fend);
    longint p [3];
    gyr_result_t r;
    bit [127:0] pos, neg, num, quo;
    bit [63:0] m;
    longint unsigned n;
    p[0] = x; p[1] = y; p[2] = z;
    if (c >= sh_first && c <= sh_last) begin
      if (sh_count[c] < MAX_ATOMS) begin
        sh_count[c]++;
        for (int a = 0; a < 3; a++) begin
          sh_sum[c][a] += p[a];
          sh_sq[c][a] += 64'(p[a] * p[a]);
        end
      end else
        sh_count[c] = MAX_ATOMS + 1;
    end
    if (!fend) return;
    for (int k = sh_first; k <= sh_last; k++) begin
      n = sh_count[k];
      r.frame = sh_frame;
      r.chain = CHAIN_W'(k);
      r.gyr = '0;
      r.st = STAT_OK;
      r.last = (k == sh_last);
      if (n == 0)
        r.st = STAT_EMPTY;
      else if (n > MAX_ATOMS)
        r.st = STAT_OVF;
      else begin
        pos = 0; neg = 0;
        for (int a = 0; a < 3; a++) begin
          m = sh_sum[k][a] < 0 ? 64'(-sh_sum[k][a]) : 64'(sh_sum[k][a]);
          pos += 128'(n) * 128'(sh_sq[k][a]);
          neg += 128'(m) * 128'(m);
        end
        num = pos >= neg ? pos - neg : 128'd0;
        quo = num / (128'(n) * 128'(n));
        if (quo >> GYR_W != 0) begin
          r.gyr = '1;
          r.st = STAT_OVF;
        end else
          r.gyr = quo[GYR_W-1:0];
      end
      pending_results.push_back(r);
    end
    clear_sums();
    sh_frame++;
  endfunction

  // one atom beat; valid stays high on return so back-to-back beats need no gap
  task automatic send_atom(bit [CHAIN_W-1:0] c, bit signed [POS_W-1:0] x,
                           bit signed [POS_W-1:0] y, bit signed [POS_W-1:0] z, bit fend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chain_id <= c;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_frame_end <= fend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    atoms_sent++;
    if (fend) frames_sent++;
    predict_atom(c, x, y, z, fend);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [CHAIN_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIRST) sh_first = val;
    else sh_last = val;
  endtask

  function automatic row_t atom(bit [CHAIN_W-1:0] c, int x, int y, int z, bit fend,
                                bit chk = 0, bit [GYR_W-1:0] gyr = 0, logic [1:0] st = 0);
    row_t r;
    r.kind = ROW_ATOM; r.reg_idx = CFG_FIRST; r.chain = c;
    r.x = POS_W'(x); r.y = POS_W'(y); r.z = POS_W'(z); r.fend = fend;
    r.chk = chk; r.gyr = gyr; r.st = st;
    return r;
  endfunction

  function automatic row_t cfg(logic idx, bit [CHAIN_W-1:0] val);
    row_t r;
    r = atom(val, 0, 0, 0, 0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    return r;
  endfunction

  function automatic bit signed [POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      1: return POS_W'($urandom_range(8191)) - 24'sd4096;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    gyr_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: chain %0d frame %0d", out_result_chain,
                     out_frame_number);
        end else begin
          e = pending_results.pop_front();
          if (out_frame_number !== e.frame || out_result_chain !== e.chain ||
              out_gyration_sq !== e.gyr || out_status !== e.st ||
              out_last_of_frame !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp frame %0d chain %0d gyr %h st %0d last %0b, got %0d %0d %h %0d %0b",
                       e.frame, e.chain, e.gyr, e.st, e.last, out_frame_number,
                       out_result_chain, out_gyration_sq, out_status, out_last_of_frame);
          end
        end
      end
    end
  end

  // watchdog on beats
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("timeout: no beat for %0d cycles", STALL_MAX);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    int base, seen0, idx, first, width, len;
    bit [CHAIN_W-1:0] c;
    sh_first = 0;
    sh_last = 63;
    sh_frame = 0;
    clear_sums();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: one atom on chain 0, every other chain reports empty
    rows.push_back(atom(0, 0, 0, 0, 1, 1, 0, STAT_OK));
    rows.push_back(cfg(CFG_FIRST, 2));
    rows.push_back(cfg(CFG_LAST, 4));
    rows.push_back(atom(2, -8388608, -8388608, -8388608, 0));
    rows.push_back(atom(2, 8388607, 8388607, 8388607, 0));
    rows.push_back(atom(3, 5, -7, 9, 0));
    rows.push_back(atom(9, 1234, 1234, 1234, 0));     // out of range, ignored
    rows.push_back(atom(4, 8388607, 0, -1, 1));
    rows.push_back(atom(3, 123, -456, 789, 1, 1, 0, STAT_EMPTY));
    // empty range: frame end gives nothing but advances the frame count
    rows.push_back(cfg(CFG_FIRST, 5));
    rows.push_back(atom(5, 77, 77, 77, 1));
    // range moved in the middle of a frame
    rows.push_back(cfg(CFG_FIRST, 0));
    rows.push_back(cfg(CFG_LAST, 0));
    rows.push_back(atom(0, 100, 200, 300, 0));
    rows.push_back(atom(1, 400, 500, 600, 0));
    rows.push_back(cfg(CFG_LAST, 1));
    rows.push_back(atom(1, -400, -500, -600, 0));
    rows.push_back(atom(0, -100, 0, 4096, 1));
    rows.push_back(cfg(CFG_FIRST, 63));
    rows.push_back(cfg(CFG_LAST, 63));
    rows.push_back(atom(63, -1, 8388607, -8388608, 1, 1, 0, STAT_OK));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].reg_idx, rows[i].chain);
      end else begin
        base = pending_results.size();
        seen0 = results_seen;
        send_atom(rows[i].chain, rows[i].x, rows[i].y, rows[i].z, rows[i].fend);
        // results drained while the beat waited shift the queue
        idx = base - (results_seen - seen0);
        if (rows[i].chk && (idx < 0 || pending_results.size() <= idx ||
            pending_results[idx].gyr !== rows[i].gyr ||
            pending_results[idx].st !== rows[i].st)) begin
          mismatches++;
          $display("directed row %0d: first result differs from table", i);
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 29 : phase == 1 ? 45 : 0;
      recv_idle_pct = phase == 0 ? 45 : phase == 1 ? 29 : 0;
      base = atoms_sent;
      while (atoms_sent - base < 80) begin
        first = $urandom_range(63);
        width = $urandom_range(9) == 0 ? -1 : $urandom_range(3);
        if (phase == 2 && atoms_sent == base) begin
          first = 0;
          width = 63;
        end
        write_reg(CFG_FIRST, CHAIN_W'(first));
        write_reg(CFG_LAST, CHAIN_W'(width < 0 ? first - 1
                                               : (first + width > 63 ? 63 : first + width)));
        // let the output back up behind a long stall while atoms keep coming
        if (phase == 2 && width == 63) hold_left = 400;
        for (int f = 0; f < 3; f++) begin
          len = phase == 2 && f == 0 && width == 63 ? 30 : $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            c = $urandom_range(4) == 0 ? CHAIN_W'($urandom)
                                       : CHAIN_W'(first + $urandom_range(width < 0 ? 0 : width));
            send_atom(c, rand_pos(), rand_pos(), rand_pos(), i == len - 1);
          end
        end
      end
    end

    wait_idle();
    $display("covered %0d atoms in %0d frames, %0d results checked, %0d mismatches",
             atoms_sent, frames_sent, results_seen, mismatches);
    $display("includes extreme coordinates, empty chains and ranges, mid-frame range changes");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
